[sv/lru_chunk_residency_tracker_assert.svh]
// Assertion macros shared by the chunk residency tracker RTL.
`ifndef LRU_CHUNK_RESIDENCY_TRACKER_ASSERT_SVH
`define LRU_CHUNK_RESIDENCY_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LCRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LCRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lcrt_pkg.sv]
// Types and constants shared by the chunk residency tracker modules.
package lcrt_pkg;

  localparam int TAG_W       = 28;
  localparam int STAMP_W     = 64;
  localparam int WORD_W      = 2 * TAG_W + STAMP_W;
  localparam int CFG_W       = 5;
  localparam int SLOT_OUT_W  = 4;
  localparam int COUNT_OUT_W = 5;
  localparam int EV_CNT_W    = 4;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;

  localparam logic [EV_CNT_W-1:0] MAX_EVICT     = 4'd15;
  localparam logic [CFG_W-1:0]    CAPACITY_RST  = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_DECIDE = 4'b1000
  } lcrt_state_e;

  typedef struct packed {
    logic done;
    logic hit;
    logic have_min;
    logic have_free;
  } lcrt_scan_flags_t;

endpackage

[sv/lcrt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module lcrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/lcrt_scan.sv]
// Slot scan unit: accumulates tag match, least-recent slot and first free slot.
module lcrt_scan import lcrt_pkg::*; #(
  parameter int SLOTS = 16,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              rd_vld_i,
  input  logic              rd_last_i,
  input  logic [IDX_W-1:0]  rd_idx_i,
  input  logic              rd_slot_vld_i,
  input  logic [WORD_W-1:0] rd_data_i,
  input  logic [TAG_W-1:0]  key_x_i,
  input  logic [TAG_W-1:0]  key_y_i,
  output lcrt_scan_flags_t  flags_o,
  output logic [IDX_W-1:0]  hit_idx_o,
  output logic [IDX_W-1:0]  min_idx_o,
  output logic [TAG_W-1:0]  min_tx_o,
  output logic [TAG_W-1:0]  min_ty_o,
  output logic [IDX_W-1:0]  free_idx_o
);

  lcrt_scan_flags_t   flags_q, flags_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]   min_idx_q, min_idx_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [TAG_W-1:0]   min_tx_q, min_tx_d;
  logic [TAG_W-1:0]   min_ty_q, min_ty_d;
  logic [STAMP_W-1:0] min_st_q, min_st_d;
  logic [TAG_W-1:0]   rd_tx;
  logic [TAG_W-1:0]   rd_ty;
  logic [STAMP_W-1:0] rd_st;

  assign rd_tx = rd_data_i[TAG_W-1:0];
  assign rd_ty = rd_data_i[2*TAG_W-1:TAG_W];
  assign rd_st = rd_data_i[WORD_W-1:2*TAG_W];

  always_comb begin
    flags_d    = flags_q;
    hit_idx_d  = hit_idx_q;
    min_idx_d  = min_idx_q;
    free_idx_d = free_idx_q;
    min_tx_d   = min_tx_q;
    min_ty_d   = min_ty_q;
    min_st_d   = min_st_q;
    if (start_i) begin
      flags_d = '0;
    end else if (rd_vld_i) begin
      if (rd_slot_vld_i && rd_tx == key_x_i && rd_ty == key_y_i && !flags_q.hit) begin
        flags_d.hit = 1'b1;
        hit_idx_d   = rd_idx_i;
      end
      if (rd_slot_vld_i && (!flags_q.have_min || rd_st < min_st_q)) begin
        flags_d.have_min = 1'b1;
        min_idx_d        = rd_idx_i;
        min_tx_d         = rd_tx;
        min_ty_d         = rd_ty;
        min_st_d         = rd_st;
      end
      if (!rd_slot_vld_i && !flags_q.have_free) begin
        flags_d.have_free = 1'b1;
        free_idx_d        = rd_idx_i;
      end
      if (rd_last_i) begin
        flags_d.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    min_idx_q  <= min_idx_d;
    free_idx_q <= free_idx_d;
    min_tx_q   <= min_tx_d;
    min_ty_q   <= min_ty_d;
    min_st_q   <= min_st_d;
  end

  assign flags_o    = flags_q;
  assign hit_idx_o  = hit_idx_q;
  assign min_idx_o  = min_idx_q;
  assign min_tx_o   = min_tx_q;
  assign min_ty_o   = min_ty_q;
  assign free_idx_o = free_idx_q;

endmodule

[sv/lru_chunk_residency_tracker.sv]
// Top level of the LRU chunk residency tracker.
//
//   Channel   Direction  Request content
//   s_axis    in         block_x, block_y
//   m_axis    out        one result per eviction, then the access report (tlast)
//   cfg       in         capacity
//
// Each request or eviction re-scans the tag RAM one slot per cycle through its read port.
// A result waiting at m_axis stalls only the next result, not the next request.
// Reset clears all valid bits, the access clock and the occupancy; no clearing pass runs.
module lru_chunk_residency_tracker import lcrt_pkg::*; #(
  parameter int SLOTS       = 16,
  parameter int CHUNK_SHIFT = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] block_x, [63:32] block_y
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [3:0] slot, [31:4] chunk_x, [59:32] chunk_y, [64:60] resident_count, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] is_eviction, [1] hit
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OCC_W = $clog2(SLOTS + 1);
  localparam int CAP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  lcrt_state_e        state_q, state_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic               first_q, first_d;
  logic [EV_CNT_W-1:0] ev_cnt_q, ev_cnt_d;
  logic [TAG_W-1:0]   cx_q, cx_d;
  logic [TAG_W-1:0]   cy_q, cy_d;
  logic [STAMP_W-1:0] clock_q, clock_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [CFG_W-1:0]   cap_q, cap_d;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic               rd_vld_q, rd_last_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               rd_sv_q;

  logic               out_valid_q, out_valid_d;
  logic               out_ev_q, out_hit_q, out_last_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [TAG_W-1:0]   out_cx_q, out_cy_q;
  logic [OCC_W-1:0]   out_occ_q;

  logic               ld;
  logic               ld_ev, ld_hit;
  logic [IDX_W-1:0]   ld_idx;
  logic [TAG_W-1:0]   ld_cx, ld_cy;
  logic [OCC_W-1:0]   ld_occ;

  logic               accept;
  logic               out_free;
  logic               scan_start;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;
  logic [STAMP_W-1:0] clock_inc;
  logic signed [31:0] bx_shift, by_shift;
  logic [CAP_W-1:0]   cap_nz, cap_eff;
  logic               need_evict;
  logic [OCC_W-1:0]   occ_dec;
  logic [IDX_W-1:0]   ins_idx;
  logic [IDX_W+SLOT_OUT_W-1:0]  slot_wide;
  logic [OCC_W+COUNT_OUT_W-1:0] count_wide;

  lcrt_scan_flags_t   flags;
  logic [IDX_W-1:0]   hit_idx, min_idx, free_idx;
  logic [TAG_W-1:0]   min_tx, min_ty;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign clock_inc     = clock_q + STAMP_W'(1);

  assign bx_shift = $signed(s_axis_tdata[31:0]) >>> CHUNK_SHIFT;
  assign by_shift = $signed(s_axis_tdata[63:32]) >>> CHUNK_SHIFT;

  assign cap_nz     = (cap_q == '0) ? CAP_W'(1) : CAP_W'(cap_q);
  assign cap_eff    = (cap_nz > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : cap_nz;
  assign need_evict = (CAP_W'(occ_q) >= cap_eff) && (ev_cnt_q < MAX_EVICT) && flags.have_min;
  assign occ_dec    = (occ_q != '0) ? occ_q - OCC_W'(1) : occ_q;
  assign ins_idx    = flags.have_free ? free_idx : '0;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    first_d    = first_q;
    ev_cnt_d   = ev_cnt_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    clock_d    = clock_q;
    occ_d      = occ_q;
    valid_d    = valid_q;
    scan_start = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ins_idx;
    ram_wdata  = {clock_inc, cy_q, cx_q};
    ld         = 1'b0;
    ld_ev      = 1'b0;
    ld_hit     = 1'b0;
    ld_idx     = ins_idx;
    ld_cx      = cx_q;
    ld_cy      = cy_q;
    ld_occ     = occ_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cx_d       = bx_shift[TAG_W-1:0];
          cy_d       = by_shift[TAG_W-1:0];
          first_d    = 1'b1;
          ev_cnt_d   = '0;
          cnt_d      = '0;
          scan_start = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == LAST_IDX) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (flags.done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          ld = 1'b1;
          if (first_q && flags.hit) begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx;
            clock_d   = clock_inc;
            ld_hit    = 1'b1;
            ld_idx    = hit_idx;
            state_d   = ST_IDLE;
          end else if (need_evict) begin
            valid_d[min_idx] = 1'b0;
            occ_d            = occ_dec;
            ev_cnt_d         = ev_cnt_q + EV_CNT_W'(1);
            first_d          = 1'b0;
            ld_ev            = 1'b1;
            ld_idx           = min_idx;
            ld_cx            = min_tx;
            ld_cy            = min_ty;
            ld_occ           = occ_dec;
            cnt_d            = '0;
            scan_start       = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            ram_we           = 1'b1;
            valid_d[ins_idx] = 1'b1;
            clock_d          = clock_inc;
            if (flags.have_free) begin
              occ_d  = occ_q + OCC_W'(1);
              ld_occ = occ_q + OCC_W'(1);
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cap_d = cap_q;
    if (cfg_valid_i) begin
      cap_d = cfg_data_i;
    end
    out_valid_d = out_valid_q && !m_axis_tready;
    if (ld) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      first_q     <= 1'b0;
      ev_cnt_q    <= '0;
      clock_q     <= '0;
      occ_q       <= '0;
      cap_q       <= CAPACITY_RST;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      ev_cnt_q    <= ev_cnt_d;
      clock_q     <= clock_d;
      occ_q       <= occ_d;
      cap_q       <= cap_d;
      valid_q     <= valid_d;
      rd_vld_q    <= (state_q == ST_SCAN);
      rd_last_q   <= (state_q == ST_SCAN) && (cnt_q == LAST_IDX);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    rd_idx_q <= cnt_q;
    rd_sv_q  <= valid_q[cnt_q];
    if (ld) begin
      out_ev_q   <= ld_ev;
      out_hit_q  <= ld_hit;
      out_last_q <= !ld_ev;
      out_idx_q  <= ld_idx;
      out_cx_q   <= ld_cx;
      out_cy_q   <= ld_cy;
      out_occ_q  <= ld_occ;
    end
  end

  lcrt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (state_q == ST_SCAN),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  lcrt_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (scan_start),
    .rd_vld_i      (rd_vld_q),
    .rd_last_i     (rd_last_q),
    .rd_idx_i      (rd_idx_q),
    .rd_slot_vld_i (rd_sv_q),
    .rd_data_i     (ram_rdata),
    .key_x_i       (cx_q),
    .key_y_i       (cy_q),
    .flags_o       (flags),
    .hit_idx_o     (hit_idx),
    .min_idx_o     (min_idx),
    .min_tx_o      (min_tx),
    .min_ty_o      (min_ty),
    .free_idx_o    (free_idx)
  );

  assign slot_wide  = {{SLOT_OUT_W{1'b0}}, out_idx_q};
  assign count_wide = {{COUNT_OUT_W{1'b0}}, out_occ_q};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_hit_q, out_ev_q};
  assign m_axis_tdata  = {7'd0, count_wide[COUNT_OUT_W-1:0], out_cy_q, out_cx_q,
                          slot_wide[SLOT_OUT_W-1:0]};

  `include "lru_chunk_residency_tracker_assert.svh"

  `LCRT_ASSERT_IMPL(a_occ_bound, 1'b1, occ_q <= OCC_W'(SLOTS), "Occupancy exceeds slot count.")
  `LCRT_ASSERT_NEXT(a_accept_scans, accept, state_q == ST_SCAN, "Request did not start a scan.")
  `LCRT_ASSERT_IMPL(a_idle_no_read, state_q == ST_IDLE, !rd_vld_q, "Read data pending while idle.")
  `LCRT_ASSERT_IMPL(a_evict_not_last, out_valid_q && out_ev_q, !out_last_q && !out_hit_q,
                    "Eviction result marked as access report.")

endmodule
